// ===== rtl/ccpa_pkg.sv =====
// Package for the column cost path accumulator: field widths, fixed constants
// and the sequencer state type. No dependencies.
package ccpa_pkg;

  localparam int unsigned LC_W    = 24;  // local cost, signed Q15.8
  localparam int unsigned ROW_W   = 10;  // row index and band limits
  localparam int unsigned DELTA_W = 3;   // step limit field
  localparam int unsigned COST_W  = 32;  // path cost, signed Q23.8
  localparam int unsigned NPC_W   = 31;  // no-path cost, unsigned Q23.8
  localparam int unsigned BEST_W  = 33;  // running minimum, holds both ranges
  localparam int unsigned ADD_W   = 34;  // shared adder width
  localparam int unsigned IDX_W   = 14;  // signed window row index
  localparam int unsigned DLIM_W  = 4;   // clamped step limit
  localparam int unsigned CNT_W   = 5;   // window position, up to 2*MaxDelta
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 2;

  // Byte address of the no-path cost register.
  localparam logic [APB_AW-1:0] NoPathCostAddr = APB_AW'(0);

  // Largest vertical step honored; larger step limits are clamped to it.
  localparam logic [DLIM_W-1:0] MaxDelta = DLIM_W'(7);

  localparam logic [NPC_W-1:0]  NoPathCostRst = {NPC_W{1'b1}};
  localparam logic [COST_W-1:0] CostMax = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic [COST_W-1:0] CostMin = {1'b1, {(COST_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SUM,
    ST_OUT,
    ST_COPY
  } ccpa_state_e;

endpackage

// ===== rtl/ccpa_in_if.sv =====
// Input channel of the column cost path accumulator: one pixel item per handshake.
// Depends on ccpa_pkg for the field widths.
interface ccpa_in_if;
  import ccpa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LC_W-1:0]    local_cost;
  logic [ROW_W-1:0]          row;
  logic [ROW_W-1:0]          col_upper;
  logic [ROW_W-1:0]          col_lower;
  logic [DELTA_W-1:0]        col_delta;
  logic                      first_column;
  logic                      last_in_column;

  modport source (
    output valid, local_cost, row, col_upper, col_lower, col_delta,
           first_column, last_in_column,
    input  ready
  );

  modport sink (
    input  valid, local_cost, row, col_upper, col_lower, col_delta,
           first_column, last_in_column,
    output ready
  );

endinterface

// ===== rtl/ccpa_out_if.sv =====
// Output channel of the column cost path accumulator: one result item per handshake.
// Depends on ccpa_pkg for the field widths.
interface ccpa_out_if;
  import ccpa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COST_W-1:0]  path_cost;
  logic [ROW_W-1:0]          row_out;
  logic                      saturated;

  modport source (
    output valid, path_cost, row_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, path_cost, row_out, saturated,
    output ready
  );

endinterface

// ===== rtl/ccpa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ccpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/column_cost_path_accumulator.sv =====
// Top level of the column cost path accumulator: sequencer, shared adder,
// column stores and APB register. Depends on ccpa_pkg, ccpa_in_if, ccpa_out_if, ccpa_ram.
//
//   Channel   Direction  Handshake          Carries
//   in_if     sink       valid / ready      local_cost, row, band, delta, column flags
//   out_if    source     valid / ready      path_cost, row_out, saturated
//   APB       slave      psel/penable       no_path_cost at byte address 0
//
// A pixel outside the band, or in the first column, occupies the block for the
// accepting cycle, the sum and the cycle that loads the result, so the next item
// can be accepted in the cycle after the load. A pixel inside the band also
// scans the window of rows row - d to row + d first, where d is the previous
// column's clamped step limit: the previous-column store has one read port, so
// the window is read one row per cycle, and a drain step then takes the last read.
// The last pixel of a column adds, before the next item is accepted, a copy of
// the current store into the previous store, one entry per cycle.
// After reset the block is idle and ready; the stores are not cleared.
// A stalled output holds its result; the sequencer then waits before loading.
module column_cost_path_accumulator #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccpa_in_if.sink                       in_if,
  ccpa_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccpa_pkg::APB_AW-1:0]   paddr,
  input  logic [ccpa_pkg::APB_DW-1:0]   pwdata,
  output logic [ccpa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ccpa_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ROWS);
  localparam int unsigned CPW = AW + 1;  // copy counter, reaches MAX_ROWS

  // Sequencer state.
  ccpa_state_e state_q, state_d;

  // Captured input item.
  logic signed [LC_W-1:0] local_q;
  logic [ROW_W-1:0]       row_q;
  logic [ROW_W-1:0]       upper_q;
  logic [ROW_W-1:0]       lower_q;
  logic [DELTA_W-1:0]     delta_q;
  logic                   last_q;
  logic                   pass_q;

  // Previous column's band and step limit.
  logic [ROW_W-1:0]   prev_upper_q;
  logic [ROW_W-1:0]   prev_lower_q;
  logic [DELTA_W-1:0] prev_delta_q;

  // Configuration register.
  logic [NPC_W-1:0] no_path_cost_q;

  // Window search.
  logic signed [BEST_W-1:0] best_q, best_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     use_q, use_d;

  // Result register.
  logic [COST_W-1:0]  res_q, res_d;
  logic               sat_q, sat_d;

  // Output register.
  logic              out_valid_q;
  logic [COST_W-1:0] out_cost_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_sat_q;

  // Copy sweep.
  logic [CPW-1:0] cp_cnt_q;
  logic           cp_wr_q;
  logic [AW-1:0]  cp_addr_q;

  // Control decoded from the state.
  logic in_acc;
  logic out_load;
  logic scan_en;
  logic cmp_en;
  logic copy_en;

  logic [COST_W-1:0] prev_rdata;
  logic [COST_W-1:0] cur_rdata;

  // ---------------------------------------------------------------------------
  // Window geometry: the window runs from row - d to row + d, and a row counts
  // only inside the store and inside the previous column's band.
  // ---------------------------------------------------------------------------
  logic [DLIM_W-1:0]       dlim;
  logic signed [IDX_W-1:0] k_idx;
  logic                    k_usable;
  logic [IDX_W-1:0]        row_idx;
  logic                    row_in_store;
  logic                    scan_last;

  assign dlim = ({1'b0, prev_delta_q} > MaxDelta) ? MaxDelta : {1'b0, prev_delta_q};
  assign k_idx = $signed({{(IDX_W-ROW_W){1'b0}}, row_q})
               - $signed({{(IDX_W-DLIM_W){1'b0}}, dlim})
               + $signed({{(IDX_W-CNT_W){1'b0}}, cnt_q});
  assign k_usable = (k_idx >= 0)
                 && (k_idx < $signed(IDX_W'(MAX_ROWS)))
                 && (k_idx >= $signed({{(IDX_W-ROW_W){1'b0}}, prev_upper_q}))
                 && (k_idx <= $signed({{(IDX_W-ROW_W){1'b0}}, prev_lower_q}));
  assign scan_last = (cnt_q == {dlim, 1'b0});

  assign row_idx      = {{(IDX_W-ROW_W){1'b0}}, row_q};
  assign row_in_store = (row_idx < IDX_W'(MAX_ROWS));

  // ---------------------------------------------------------------------------
  // Shared adder. While scanning it subtracts the running minimum from the
  // word just read, and the sign tells whether that word is smaller. In the
  // sum step it adds the local cost to the minimum.
  // ---------------------------------------------------------------------------
  logic [ADD_W-1:0] add_a, add_b, add_y;
  logic             add_sub;

  always_comb begin
    if (state_q == ST_SUM) begin
      add_a   = ADD_W'(local_q);
      add_b   = ADD_W'(best_q);
      add_sub = 1'b0;
    end else begin
      add_a   = ADD_W'($signed(prev_rdata));
      add_b   = ADD_W'(best_q);
      add_sub = 1'b1;
    end
  end

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

  // The sum fits when its three top bits agree; otherwise clamp toward its sign.
  logic sum_ovf;
  assign sum_ovf = !((add_y[ADD_W-1:COST_W-1] == '0) || (add_y[ADD_W-1:COST_W-1] == '1));

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (in_if.first_column || (in_if.row < in_if.col_upper)
              || (in_if.row > in_if.col_lower)) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          state_d = last_q ? ST_COPY : ST_IDLE;
        end
      end
      ST_COPY: begin
        if (cp_cnt_q == CPW'(MAX_ROWS)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs of the sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_acc   = 1'b0;
    out_load = 1'b0;
    scan_en  = 1'b0;
    cmp_en   = 1'b0;
    copy_en  = 1'b0;
    case (state_q)
      ST_IDLE:  in_acc   = in_if.valid;
      ST_SCAN: begin
        scan_en = 1'b1;
        cmp_en  = use_q;
      end
      ST_DRAIN: cmp_en   = use_q;
      ST_OUT:   out_load = !out_valid_q || out_if.ready;
      ST_COPY:  copy_en  = (cp_cnt_q < CPW'(MAX_ROWS));
      default: ;
    endcase
  end

  assign in_if.ready = (state_q == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Datapath next values.
  // ---------------------------------------------------------------------------
  always_comb begin
    best_d = best_q;
    cnt_d  = cnt_q;
    use_d  = scan_en && k_usable;
    res_d  = res_q;
    sat_d  = sat_q;
    if (in_acc) begin
      best_d = $signed({2'b00, no_path_cost_q});
      cnt_d  = '0;
    end
    if (scan_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmp_en && add_y[ADD_W-1]) begin
      best_d = BEST_W'($signed(prev_rdata));
    end
    if (state_q == ST_SUM) begin
      if (pass_q) begin
        res_d = COST_W'(local_q);
        sat_d = 1'b0;
      end else if (sum_ovf) begin
        res_d = add_y[ADD_W-1] ? CostMin : CostMax;
        sat_d = 1'b1;
      end else begin
        res_d = add_y[COST_W-1:0];
        sat_d = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      use_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      cp_wr_q        <= 1'b0;
      cp_cnt_q       <= '0;
      prev_upper_q   <= '0;
      prev_lower_q   <= '0;
      prev_delta_q   <= '0;
      no_path_cost_q <= NoPathCostRst;
    end else begin
      state_q <= state_d;
      use_q   <= use_d;
      cp_wr_q <= copy_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (out_load && last_q) begin
        cp_cnt_q     <= '0;
        prev_upper_q <= upper_q;
        prev_lower_q <= lower_q;
        prev_delta_q <= delta_q;
      end else if (copy_en) begin
        cp_cnt_q <= cp_cnt_q + CPW'(1);
      end
      if (psel && penable && pwrite) begin
        no_path_cost_q <= pwdata[NPC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    sat_q  <= sat_d;
    if (in_acc) begin
      local_q <= in_if.local_cost;
      row_q   <= in_if.row;
      upper_q <= in_if.col_upper;
      lower_q <= in_if.col_lower;
      delta_q <= in_if.col_delta;
      last_q  <= in_if.last_in_column;
      pass_q  <= in_if.first_column || (in_if.row < in_if.col_upper)
              || (in_if.row > in_if.col_lower);
    end
    if (out_load) begin
      out_cost_q <= res_q;
      out_row_q  <= row_q;
      out_sat_q  <= sat_q;
    end
    cp_addr_q <= cp_cnt_q[AW-1:0];
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.path_cost = out_cost_q;
  assign out_if.row_out   = out_row_q;
  assign out_if.saturated = out_sat_q;

  // Reads of any other address return zero.
  assign prdata = (paddr == NoPathCostAddr) ? APB_DW'(no_path_cost_q) : '0;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Column stores. Every result whose row lies inside the store is written into
  // the current store as it is loaded for output; at a column end the whole
  // current store is swept into the previous store, which the window search reads.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] k_addr;
  assign k_addr = k_idx;

  ccpa_ram #(
    .Width (COST_W),
    .Depth (MAX_ROWS)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (out_load && row_in_store),
    .waddr_i (row_idx[AW-1:0]),
    .wdata_i (res_q),
    .re_i    (copy_en),
    .raddr_i (cp_cnt_q[AW-1:0]),
    .rdata_o (cur_rdata)
  );

  ccpa_ram #(
    .Width (COST_W),
    .Depth (MAX_ROWS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (cp_wr_q),
    .waddr_i (cp_addr_q),
    .wdata_i (cur_rdata),
    .re_i    (scan_en),
    .raddr_i (k_addr[AW-1:0]),
    .rdata_o (prev_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= {dlim, 1'b0}))
    else $error("window scan ran past its last row");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.saturated) |->
      ((out_if.path_cost == CostMax) || (out_if.path_cost == CostMin)))
    else $error("saturated result is not clamped to a range limit");

  a_col_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> !in_if.ready)
    else $error("block ready during column copy");

  a_prev_write_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_wr_q |-> (state_q == ST_COPY))
    else $error("previous store written outside the copy sweep");

endmodule
